### rtl/psds_pkg.sv
// Shared package for the point-to-segment squared distance pipeline.
// Holds default widths, the region code type and the per-stage control struct.
// Depends on nothing.
package psds_pkg;

	localparam int COORD_BITS_DEF  = 16;
	localparam int T_FRAC_BITS_DEF = 16;
	localparam int DIST_BITS       = 34;
	localparam int OUT_W           = ((DIST_BITS + 7) / 8) * 8;

	localparam logic [DIST_BITS-1:0] DIST_MAX = '1;

	typedef enum logic [1:0] {
		REGION_INTERIOR = 2'd0,
		REGION_START    = 2'd1,
		REGION_END      = 2'd2,
		REGION_ZERO     = 2'd3
	} region_t;

	// Control that travels with every pipeline stage.
	typedef struct packed {
		logic    valid;
		region_t region;
	} stage_ctl_t;

endpackage

### rtl/psds_front.sv
// Front end: segment and offset vectors, their products, squared length and dot
// product, and the region decision. Four register stages.
// Depends on psds_pkg.
module psds_front #(
	parameter int COORD_BITS = psds_pkg::COORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         in_valid,
	input  logic signed [COORD_BITS-1:0] start_x,
	input  logic signed [COORD_BITS-1:0] start_y,
	input  logic signed [COORD_BITS-1:0] end_x,
	input  logic signed [COORD_BITS-1:0] end_y,
	input  logic signed [COORD_BITS-1:0] point_x,
	input  logic signed [COORD_BITS-1:0] point_y,
	output psds_pkg::stage_ctl_t         ctl_o,
	output logic [2*COORD_BITS:0]        rem_o,
	output logic [2*COORD_BITS:0]        len2_o,
	output logic signed [COORD_BITS:0]   dx_o,
	output logic signed [COORD_BITS:0]   dy_o,
	output logic signed [COORD_BITS:0]   rx_o,
	output logic signed [COORD_BITS:0]   ry_o
);

	localparam int DW   = COORD_BITS + 1;
	localparam int LW   = 2 * COORD_BITS + 1;
	localparam int PW   = 2 * DW;
	localparam int DOTW = PW + 1;

	logic                 v_s1, v_s2, v_s3;
	psds_pkg::stage_ctl_t ctl_s4;

	logic signed [DW-1:0] dx_s1, dy_s1, rx_s1, ry_s1;
	logic signed [DW-1:0] dx_s2, dy_s2, rx_s2, ry_s2;
	logic signed [DW-1:0] dx_s3, dy_s3, rx_s3, ry_s3;
	logic signed [DW-1:0] dx_s4, dy_s4, rx_s4, ry_s4;
	logic signed [PW-1:0] ddx_s2, ddy_s2, drx_s2, dry_s2;
	logic [LW-1:0]        len2_s3, len2_s4, rem_s4;
	logic signed [DOTW-1:0] dot_s3;
	logic [LW-1:0]        dot_lo;
	psds_pkg::region_t    region_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			ctl_s4 <= '0;
		end else if (en) begin
			v_s1          <= in_valid;
			v_s2          <= v_s1;
			v_s3          <= v_s2;
			ctl_s4.valid  <= v_s3;
			ctl_s4.region <= region_n;
		end
	end

	assign dot_lo = dot_s3[LW-1:0];

	// A positive dot product is below 2^LW, so its low bits compare directly.
	always_comb begin
		priority if (len2_s3 == '0) begin
			region_n = psds_pkg::REGION_ZERO;
		end else if (dot_s3[DOTW-1] || dot_s3 == '0) begin
			region_n = psds_pkg::REGION_START;
		end else if (dot_lo >= len2_s3) begin
			region_n = psds_pkg::REGION_END;
		end else begin
			region_n = psds_pkg::REGION_INTERIOR;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1 <= DW'(end_x) - DW'(start_x);
			dy_s1 <= DW'(end_y) - DW'(start_y);
			rx_s1 <= DW'(point_x) - DW'(start_x);
			ry_s1 <= DW'(point_y) - DW'(start_y);

			ddx_s2 <= dx_s1 * dx_s1;
			ddy_s2 <= dy_s1 * dy_s1;
			drx_s2 <= rx_s1 * dx_s1;
			dry_s2 <= ry_s1 * dy_s1;
			dx_s2  <= dx_s1;
			dy_s2  <= dy_s1;
			rx_s2  <= rx_s1;
			ry_s2  <= ry_s1;

			len2_s3 <= LW'(ddx_s2 + ddy_s2);
			dot_s3  <= DOTW'(drx_s2) + DOTW'(dry_s2);
			dx_s3   <= dx_s2;
			dy_s3   <= dy_s2;
			rx_s3   <= rx_s2;
			ry_s3   <= ry_s2;

			len2_s4 <= len2_s3;
			rem_s4  <= dot_lo;
			dx_s4   <= dx_s3;
			dy_s4   <= dy_s3;
			rx_s4   <= rx_s3;
			ry_s4   <= ry_s3;
		end
	end

	assign ctl_o  = ctl_s4;
	assign rem_o  = rem_s4;
	assign len2_o = len2_s4;
	assign dx_o   = dx_s4;
	assign dy_o   = dy_s4;
	assign rx_o   = rx_s4;
	assign ry_o   = ry_s4;

endmodule

### rtl/psds_div_step.sv
// One registered step of the restoring divider that forms the projection
// fraction, one quotient bit per stage. Depends on psds_pkg.
module psds_div_step #(
	parameter int LEN_W  = 2 * psds_pkg::COORD_BITS_DEF + 1,
	parameter int Q_W    = psds_pkg::T_FRAC_BITS_DEF,
	parameter int PASS_W = 4 * (psds_pkg::COORD_BITS_DEF + 1)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  psds_pkg::stage_ctl_t ctl_i,
	input  logic [LEN_W-1:0]     rem_i,
	input  logic [LEN_W-1:0]     len2_i,
	input  logic [Q_W-1:0]       q_i,
	input  logic [PASS_W-1:0]    pass_i,
	output psds_pkg::stage_ctl_t ctl_o,
	output logic [LEN_W-1:0]     rem_o,
	output logic [LEN_W-1:0]     len2_o,
	output logic [Q_W-1:0]       q_o,
	output logic [PASS_W-1:0]    pass_o
);

	psds_pkg::stage_ctl_t ctl_s1;
	logic [LEN_W-1:0]     rem_s1, len2_s1;
	logic [Q_W-1:0]       q_s1;
	logic [PASS_W-1:0]    pass_s1;

	logic [LEN_W:0]   rem2, diff;
	logic             ge;
	logic [LEN_W-1:0] rem_n;

	assign rem2  = {rem_i, 1'b0};
	assign diff  = rem2 - {1'b0, len2_i};
	assign ge    = rem2 >= {1'b0, len2_i};
	assign rem_n = ge ? diff[LEN_W-1:0] : rem2[LEN_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (en) begin
			ctl_s1 <= ctl_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s1  <= rem_n;
			len2_s1 <= len2_i;
			q_s1    <= {q_i[Q_W-2:0], ge};
			pass_s1 <= pass_i;
		end
	end

	assign ctl_o  = ctl_s1;
	assign rem_o  = rem_s1;
	assign len2_o = len2_s1;
	assign q_o    = q_s1;
	assign pass_o = pass_s1;

`ifndef SYNTH
	// For an interior projection the partial remainder must stay below the divisor.
	a_rem_below_len: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl_s1.valid && ctl_s1.region == psds_pkg::REGION_INTERIOR) |->
		(rem_s1 < len2_s1))
		else $error("divider remainder reached the divisor");
`endif

endmodule

### rtl/psds_sqr.sv
// Two-stage squarer for a wide magnitude: three half-width partial products,
// then their weighted sum. Depends on psds_pkg for the default width.
module psds_sqr #(
	parameter int MAG_W = psds_pkg::COORD_BITS_DEF + psds_pkg::T_FRAC_BITS_DEF + 1
) (
	input  logic               clk,
	input  logic               en,
	input  logic [MAG_W-1:0]   mag_i,
	output logic [2*MAG_W-1:0] sq_o
);

	localparam int H   = (MAG_W + 1) / 2;
	localparam int HI  = MAG_W - H;
	localparam int SQW = 2 * MAG_W;

	logic [HI-1:0]   a_hi;
	logic [H-1:0]    a_lo;
	logic [2*HI-1:0] hh_s1;
	logic [HI+H-1:0] hl_s1;
	logic [2*H-1:0]  ll_s1;
	logic [SQW-1:0]  sq_s2;

	assign a_hi = mag_i[MAG_W-1:H];
	assign a_lo = mag_i[H-1:0];

	always_ff @(posedge clk) begin
		if (en) begin
			hh_s1 <= a_hi * a_hi;
			hl_s1 <= a_hi * a_lo;
			ll_s1 <= a_lo * a_lo;
			sq_s2 <= (SQW'(hh_s1) << (2 * H)) + (SQW'(hl_s1) << (H + 1)) + SQW'(ll_s1);
		end
	end

	assign sq_o = sq_s2;

endmodule

### rtl/point_segment_distance_squared.sv
// An accepted request passes the front end, divider, back end and output register to m_tvalid.
// Throughput: one request per cycle unless the skid is full; the divider has one register stage per fraction bit.
// The pipeline stalls as a whole; a one-entry skid behind the output register lets
// s_tready fall only once a result is held back in the skid.
// Reset: arst_n clears all valid bits, including those of the output register and the skid.
// Depends on psds_pkg, psds_front, psds_div_step and psds_sqr.
module point_segment_distance_squared #(
	parameter int COORD_BITS  = psds_pkg::COORD_BITS_DEF,
	parameter int T_FRAC_BITS = psds_pkg::T_FRAC_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	// start_x, start_y, end_x, end_y, point_x, point_y, zero pad
	input  logic [((6*COORD_BITS+7)/8)*8-1:0]     s_tdata,
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	// dist_squared, zero pad
	output logic [psds_pkg::OUT_W-1:0]            m_tdata,
	// region
	output logic [1:0]                            m_tuser
);

	localparam int CB    = COORD_BITS;
	localparam int T     = T_FRAC_BITS;
	localparam int DW    = CB + 1;
	localparam int LW    = 2 * CB + 1;
	localparam int PASSW = 4 * DW;
	localparam int TDW   = T + 2 + DW;
	localparam int UW    = CB + T + 2;
	localparam int MAG_W = UW - 1;
	localparam int SQW   = 2 * MAG_W;
	localparam int SW    = SQW + 1 - 2 * T;
	localparam int XW    = (SW > psds_pkg::DIST_BITS) ? SW : psds_pkg::DIST_BITS;

	logic en;

	// Divider chain, index 0 is the front end output.
	psds_pkg::stage_ctl_t ctl_c  [T+1];
	logic [LW-1:0]        rem_c  [T+1];
	logic [LW-1:0]        len2_c [T+1];
	logic [T-1:0]         q_c    [T+1];
	logic [PASSW-1:0]     pass_c [T+1];

	logic signed [DW-1:0] dx_f, dy_f, rx_f, ry_f;
	logic signed [DW-1:0] dx_d, dy_d, rx_d, ry_d;

	psds_pkg::stage_ctl_t ctl_e1, ctl_e2, ctl_e3, ctl_e4, ctl_e5, ctl_e6;
	logic [T:0]            t_sel;
	logic signed [T+1:0]   t_s;
	logic signed [TDW-1:0] tdx_e1, tdy_e1;
	logic signed [DW-1:0]  rx_e1, ry_e1;
	logic signed [UW-1:0]  ux_e2, uy_e2;
	logic [MAG_W-1:0]      mx_e3, my_e3;
	logic [SQW-1:0]        sqx, sqy;
	logic [SQW:0]          sum_sq;
	logic [XW-1:0]         shx;
	logic [psds_pkg::DIST_BITS-1:0] dist_e6;

	logic                           out_valid_q, skid_valid_q;
	logic [psds_pkg::DIST_BITS-1:0] dist_q, skid_dist_q;
	psds_pkg::region_t              region_q, skid_region_q;

	assign en       = !skid_valid_q;
	assign s_tready = en;

	psds_front #(.COORD_BITS(CB)) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_valid(s_tvalid),
		.start_x (signed'(s_tdata[0*CB +: CB])),
		.start_y (signed'(s_tdata[1*CB +: CB])),
		.end_x   (signed'(s_tdata[2*CB +: CB])),
		.end_y   (signed'(s_tdata[3*CB +: CB])),
		.point_x (signed'(s_tdata[4*CB +: CB])),
		.point_y (signed'(s_tdata[5*CB +: CB])),
		.ctl_o   (ctl_c[0]),
		.rem_o   (rem_c[0]),
		.len2_o  (len2_c[0]),
		.dx_o    (dx_f),
		.dy_o    (dy_f),
		.rx_o    (rx_f),
		.ry_o    (ry_f)
	);

	assign q_c[0]    = '0;
	assign pass_c[0] = {ry_f, rx_f, dy_f, dx_f};

	for (genvar g = 0; g < T; g++) begin : g_div
		psds_div_step #(.LEN_W(LW), .Q_W(T), .PASS_W(PASSW)) u_step (
			.clk   (clk),
			.arst_n(arst_n),
			.en    (en),
			.ctl_i (ctl_c[g]),
			.rem_i (rem_c[g]),
			.len2_i(len2_c[g]),
			.q_i   (q_c[g]),
			.pass_i(pass_c[g]),
			.ctl_o (ctl_c[g+1]),
			.rem_o (rem_c[g+1]),
			.len2_o(len2_c[g+1]),
			.q_o   (q_c[g+1]),
			.pass_o(pass_c[g+1])
		);
	end

	assign dx_d = signed'(pass_c[T][0*DW +: DW]);
	assign dy_d = signed'(pass_c[T][1*DW +: DW]);
	assign rx_d = signed'(pass_c[T][2*DW +: DW]);
	assign ry_d = signed'(pass_c[T][3*DW +: DW]);

	always_comb begin
		unique case (ctl_c[T].region)
			psds_pkg::REGION_END:      t_sel = {1'b1, {T{1'b0}}};
			psds_pkg::REGION_INTERIOR: t_sel = {1'b0, q_c[T]};
			psds_pkg::REGION_START,
			psds_pkg::REGION_ZERO:     t_sel = '0;
		endcase
	end

	assign t_s = signed'({1'b0, t_sel});

	psds_sqr #(.MAG_W(MAG_W)) u_sqr_x (.clk(clk), .en(en), .mag_i(mx_e3), .sq_o(sqx));
	psds_sqr #(.MAG_W(MAG_W)) u_sqr_y (.clk(clk), .en(en), .mag_i(my_e3), .sq_o(sqy));

	// The squared sum is a Q(SW).(2*T) value; the shift floors it to an integer.
	assign sum_sq = (SQW+1)'(sqx) + (SQW+1)'(sqy);
	assign shx    = XW'(sum_sq >> (2 * T));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_e1 <= '0;
			ctl_e2 <= '0;
			ctl_e3 <= '0;
			ctl_e4 <= '0;
			ctl_e5 <= '0;
			ctl_e6 <= '0;
		end else if (en) begin
			ctl_e1 <= ctl_c[T];
			ctl_e2 <= ctl_e1;
			ctl_e3 <= ctl_e2;
			ctl_e4 <= ctl_e3;
			ctl_e5 <= ctl_e4;
			ctl_e6 <= ctl_e5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tdx_e1 <= t_s * dx_d;
			tdy_e1 <= t_s * dy_d;
			rx_e1  <= rx_d;
			ry_e1  <= ry_d;

			ux_e2 <= (UW'(rx_e1) <<< T) - UW'(tdx_e1);
			uy_e2 <= (UW'(ry_e1) <<< T) - UW'(tdy_e1);

			mx_e3 <= ux_e2[UW-1] ? MAG_W'(-ux_e2) : MAG_W'(ux_e2);
			my_e3 <= uy_e2[UW-1] ? MAG_W'(-uy_e2) : MAG_W'(uy_e2);

			dist_e6 <= (shx > XW'(psds_pkg::DIST_MAX)) ? psds_pkg::DIST_MAX
			                                           : psds_pkg::DIST_BITS'(shx);
		end
	end

	// Output register with a one-entry skid behind it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (en) begin
			if (!out_valid_q || m_tready) begin
				out_valid_q <= ctl_e6.valid;
			end else begin
				skid_valid_q <= ctl_e6.valid;
			end
		end else if (m_tready) begin
			out_valid_q  <= 1'b1;
			skid_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (!out_valid_q || m_tready) begin
				dist_q   <= dist_e6;
				region_q <= ctl_e6.region;
			end else begin
				skid_dist_q   <= dist_e6;
				skid_region_q <= ctl_e6.region;
			end
		end else if (m_tready) begin
			dist_q   <= skid_dist_q;
			region_q <= skid_region_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = psds_pkg::OUT_W'(dist_q);
	assign m_tuser  = region_q;

`ifndef SYNTH
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> m_tvalid)
		else $error("skid entry held while output register is empty");

	a_skid_capture: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tready && ctl_e6.valid && m_tvalid && !m_tready) |=> skid_valid_q)
		else $error("result arriving at a stalled output was not captured");

	a_skid_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_valid_q && m_tready) |=> (m_tvalid && !skid_valid_q))
		else $error("skid entry did not move into the output register");
`endif

endmodule

### tb/tb_top.sv
// Self-checking testbench for point_segment_distance_squared.
// Streams segment/point queries under random bursts and output stalls and checks each
// squared distance and region code against a predictor; depends on psds_pkg and the RTL.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int COORD_W  = psds_pkg::COORD_BITS_DEF;
	localparam int FRAC_W   = psds_pkg::T_FRAC_BITS_DEF;
	localparam int LATENCY  = FRAC_W + 11;
	localparam int IDLE_MAX = 2000;
	localparam int N_RANDOM = 1030;

	// Packed so that start_x lands in the lowest bits of s_tdata.
	typedef struct packed {
		logic signed [COORD_W-1:0] py;
		logic signed [COORD_W-1:0] px;
		logic signed [COORD_W-1:0] ey;
		logic signed [COORD_W-1:0] ex;
		logic signed [COORD_W-1:0] sy;
		logic signed [COORD_W-1:0] sx;
	} seg_query_t;

	typedef struct {
		logic [psds_pkg::DIST_BITS-1:0] dist_sq;
		psds_pkg::region_t              region;
	} dist_result_t;

	logic                              clk;
	logic                              arst_n;
	logic                              s_tvalid;
	logic                              s_tready;
	logic [((6*COORD_W+7)/8)*8-1:0]    s_tdata;  // start_x, start_y, end_x, end_y, point_x, point_y
	logic                              m_tvalid;
	logic                              m_tready = 1'b0;
	logic [psds_pkg::OUT_W-1:0]        m_tdata;  // dist_squared, zero pad
	logic [1:0]                        m_tuser;  // region

	dist_result_t expected_dist_q[$];
	int           error_count = 0;
	int           burst_left;
	int           idle_cycles;
	int           rx_hold = 0;
	int           rx_mode = 0;

	point_segment_distance_squared i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	function automatic dist_result_t predict_distance(input seg_query_t q);
		longint              dx, dy, rx, ry, len2, dot, t, ux, uy;
		logic signed [127:0] wx, wy, sq;
		dist_result_t        r;
		dx   = longint'(q.ex) - longint'(q.sx);
		dy   = longint'(q.ey) - longint'(q.sy);
		rx   = longint'(q.px) - longint'(q.sx);
		ry   = longint'(q.py) - longint'(q.sy);
		len2 = dx * dx + dy * dy;
		dot  = rx * dx + ry * dy;
		t    = 0;
		if (len2 == 0) begin
			r.region = psds_pkg::REGION_ZERO;
		end else if (dot <= 0) begin
			r.region = psds_pkg::REGION_START;
		end else if (dot >= len2) begin
			t        = longint'(1) <<< FRAC_W;
			r.region = psds_pkg::REGION_END;
		end else begin
			// Truncating division; both operands are positive here.
			t        = (dot <<< FRAC_W) / len2;
			r.region = psds_pkg::REGION_INTERIOR;
		end
		ux = (rx <<< FRAC_W) - t * dx;
		uy = (ry <<< FRAC_W) - t * dy;
		wx = ux;
		wy = uy;
		sq = (wx * wx + wy * wy) >>> (2 * FRAC_W);
		if (sq > psds_pkg::DIST_MAX)
			r.dist_sq = psds_pkg::DIST_MAX;
		else
			r.dist_sq = sq[psds_pkg::DIST_BITS-1:0];
		return r;
	endfunction

	function automatic seg_query_t make_query(input int sx, input int sy, input int ex,
			input int ey, input int px, input int py);
		seg_query_t q;
		q.sx = sx[COORD_W-1:0];
		q.sy = sy[COORD_W-1:0];
		q.ex = ex[COORD_W-1:0];
		q.ey = ey[COORD_W-1:0];
		q.px = px[COORD_W-1:0];
		q.py = py[COORD_W-1:0];
		return q;
	endfunction

	function automatic int rand_near(input int base, input int spread);
		return base + int'($urandom_range(0, 2 * spread)) - spread;
	endfunction

	// Sends one request; the sender idles for a random gap, sometimes none, between bursts of random length.
	task automatic send_query(input seg_query_t q);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 12));
			if (gap > 0) begin
				@(negedge clk);
				s_tvalid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= q;
		do @(posedge clk); while (!s_tready);
		expected_dist_q.insert(expected_dist_q.size(), predict_distance(q));
		burst_left--;
	endtask

	task automatic test_extremes();
		send_query(make_query(-32768, -32768, -32768, -32768, -32768, -32768));
		send_query(make_query(32767, 32767, 32767, 32767, 32767, 32767));
		send_query(make_query(-32768, -32768, 32767, 32767, 32767, -32768));
		send_query(make_query(32767, -32768, -32768, 32767, -32768, -32768));
		send_query(make_query(-32768, 0, 32767, 0, 0, 32767));
		send_query(make_query(0, -32768, 0, 32767, -32768, 0));
	endtask

	task automatic test_degenerate_segments();
		// Zero-length segments, up to the largest possible distance.
		send_query(make_query(-32768, -32768, -32768, -32768, 32767, 32767));
		send_query(make_query(32767, 32767, 32767, 32767, -32768, -32768));
		send_query(make_query(100, -200, 100, -200, 100, -200));
		send_query(make_query(0, 0, 0, 0, 1, -1));
	endtask

	task automatic test_region_boundaries();
		// Point on the start, behind the start, on the end and past the end.
		send_query(make_query(-500, 300, 700, -900, -500, 300));
		send_query(make_query(-500, 300, 700, -900, -1500, 1300));
		send_query(make_query(-500, 300, 700, -900, 700, -900));
		send_query(make_query(-500, 300, 700, -900, 1700, -1800));
		// Perpendicular to the start gives a zero dot product.
		send_query(make_query(0, 0, 1000, 0, 0, 2000));
		// Perpendicular to the end: dot equals the squared length.
		send_query(make_query(0, 0, 1000, 0, 1000, -2000));
		// Interior, interior with a projection that truncates to zero, and one more zero dot product.
		send_query(make_query(-300, -300, 900, 500, 200, 400));
		send_query(make_query(-32768, -32768, 32767, 32767, -32767, -32768));
		send_query(make_query(0, 0, 3, 1, 1, 2));
		send_query(make_query(0, 0, 1, 0, 0, 5));
		send_query(make_query(5, 5, 6, 6, 6, 5));
	endtask

	task automatic test_random_queries();
		int         kind;
		int         sx, sy, ex, ey;
		seg_query_t q;
		for (int n = 0; n < N_RANDOM; n++) begin
			kind = $urandom_range(0, 9);
			sx = $urandom_range(0, 65535);
			sy = $urandom_range(0, 65535);
			case (kind)
				0, 1, 2, 3: begin
					q = make_query(sx, sy, $urandom_range(0, 65535), $urandom_range(0, 65535),
						$urandom_range(0, 65535), $urandom_range(0, 65535));
				end
				4, 5: begin
					ex = rand_near(sx, 2000);
					ey = rand_near(sy, 2000);
					q  = make_query(sx, sy, ex, ey, rand_near((sx + ex) / 2, 2500),
						rand_near((sy + ey) / 2, 2500));
				end
				6: begin
					q = make_query(sx, sy, sx, sy, rand_near(sx, 3000), rand_near(sy, 3000));
				end
				7: begin
					ex = rand_near(sx, 500);
					ey = rand_near(sy, 500);
					if ($urandom_range(0, 1) == 0)
						q = make_query(sx, sy, ex, ey, sx, sy);
					else
						q = make_query(sx, sy, ex, ey, ex, ey);
				end
				default: begin
					// Tiny coordinates hit ties and truncations often.
					q = make_query(rand_near(0, 8), rand_near(0, 8), rand_near(0, 8),
						rand_near(0, 8), rand_near(0, 12), rand_near(0, 12));
				end
			endcase
			send_query(q);
		end
	endtask

	// Receiver stalls on its own pattern: ready runs, stall runs and random toggling.
	always @(negedge clk) begin
		if (rx_hold == 0) begin
			rx_mode = $urandom_range(0, 2);
			rx_hold = (rx_mode == 1) ? int'($urandom_range(1, 20)) : int'($urandom_range(1, 60));
		end
		rx_hold--;
		case (rx_mode)
			0: m_tready <= 1'b1;
			1: m_tready <= 1'b0;
			default: m_tready <= 1'($urandom_range(0, 1));
		endcase
	end

	always @(posedge clk) begin
		dist_result_t exp_r;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_dist_q.size() == 0) begin
				$display("%0t: result with no request pending: dist=%0d region=%0d",
					$time, m_tdata[psds_pkg::DIST_BITS-1:0], m_tuser);
				error_count++;
			end else begin
				exp_r = expected_dist_q.pop_front();
				if (m_tdata[psds_pkg::DIST_BITS-1:0] !== exp_r.dist_sq) begin
					$display("%0t: dist_squared mismatch: expected %0d, actual %0d",
						$time, exp_r.dist_sq, m_tdata[psds_pkg::DIST_BITS-1:0]);
					error_count++;
				end
				if (m_tuser !== exp_r.region) begin
					$display("%0t: region mismatch: expected %0d, actual %0d",
						$time, exp_r.region, m_tuser);
					error_count++;
				end
			end
		end
	end

	// Watchdog: ends the run when nothing moves on either side for too long.
	initial begin
		idle_cycles = 0;
		while (idle_cycles < IDLE_MAX) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("Watchdog expired at %0t with %0d results pending",
			$time, expected_dist_q.size());
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		burst_left  = 0;
		arst_n      = 1'b0;
		s_tvalid    = 1'b0;
		s_tdata     = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_extremes();
		test_degenerate_segments();
		test_region_boundaries();
		test_random_queries();

		@(negedge clk);
		s_tvalid <= 1'b0;
		while (expected_dist_q.size() != 0) @(posedge clk);
		// Give a stray extra result time to show up.
		repeat (LATENCY + 5) @(posedge clk);
		if (error_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

### filelist.f
rtl/psds_pkg.sv
rtl/psds_front.sv
rtl/psds_div_step.sv
rtl/psds_sqr.sv
rtl/point_segment_distance_squared.sv
tb/tb_top.sv
